// ===== hw/rtl/jdc_pkg.sv =====
`default_nettype none
package jdc_pkg;

   localparam int JdWidth   = 55;
   localparam int FracWidth = 32;
   localparam int DayWidth  = 24;
   localparam int Stages    = 8;

   localparam logic [FracWidth-1:0] HalfDay    = 32'h8000_0000;
   localparam logic [DayWidth-1:0]  GregStart  = 24'd2299161;
   localparam logic [25:0]          AlphaBias  = 26'd7468865;
   localparam logic [23:0]          BOffset    = 24'd1524;
   localparam logic [27:0]          CBias      = 28'd2442;
   localparam logic [25:0]          DMul       = 26'd1461;
   localparam logic [15:0]          YearOffMar = 16'd4716;
   localparam logic [15:0]          YearOffJan = 16'd4715;
   localparam logic [16:0]          SecPerDay  = 17'd86400;
   localparam logic [16:0]          SecPerHour = 17'd3600;
   localparam logic [11:0]          SecPerMin  = 12'd60;
   localparam logic [6:0]           Century    = 7'd100;
   localparam logic [2:0]           WeekLen    = 3'd7;

   // reciprocal multipliers: floor(n / d) = (n * ceil(2^s / d)) >> s, 2^s > nmax * d
   localparam int          AlphaShift = 43;
   localparam logic [25:0] AlphaMul   = 26'(((64'd1 << AlphaShift) + 64'd146096) / 64'd146097);
   localparam int          CentShift  = 41;
   localparam logic [28:0] CentMul    = 29'(((64'd1 << CentShift) + 64'd7304) / 64'd7305);
   localparam int          WeekShift  = 27;
   localparam logic [24:0] WeekMul    = 25'(((64'd1 << WeekShift) + 64'd6) / 64'd7);
   localparam int          HourShift  = 29;
   localparam logic [17:0] HourMul    = 18'(((64'd1 << HourShift) + 64'd3599) / 64'd3600);
   localparam int          MinShift   = 18;
   localparam logic [12:0] MinMul     = 13'(((64'd1 << MinShift) + 64'd59) / 64'd60);
   localparam int          YearShift  = 22;
   localparam logic [15:0] YearMul    = 16'(((64'd1 << YearShift) + 64'd99) / 64'd100);

   typedef logic [8:0] tbl_type [16];
   typedef logic [8:0] th_type [15];

   // floor(30.6001 * e)
   function automatic tbl_type build_day_base();
      tbl_type t;
      for (int i = 0; i < 16; i++) begin
         t[i] = 9'((306001 * i) / 10000);
      end
      return t;
   endfunction

   // ceil(30.6001 * (i + 1)): e is the count of thresholds reached
   function automatic th_type build_e_thresh();
      th_type t;
      for (int i = 0; i < 15; i++) begin
         t[i] = 9'((306001 * (i + 1) + 9999) / 10000);
      end
      return t;
   endfunction

   // floor(275 * m / 9)
   function automatic tbl_type build_month_base();
      tbl_type t;
      for (int i = 0; i < 16; i++) begin
         t[i] = 9'((275 * i) / 9);
      end
      return t;
   endfunction

   localparam tbl_type DayBase   = build_day_base();
   localparam th_type  EThresh   = build_e_thresh();
   localparam tbl_type MonthBase = build_month_base();

   typedef struct packed {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [2:0]         weekday;
      logic [8:0]         doy;
      logic               greg;
   } date_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } time_type;

endpackage
`default_nettype wire

// ===== hw/rtl/jdc_date.sv =====
`default_nettype none
module jdc_date (
   input  wire logic                          clock,
   input  wire logic [jdc_pkg::DayWidth-1:0]  z,
   output jdc_pkg::date_type                  date_out
);
   import jdc_pkg::*;

   // stage 2
   logic [25:0] num_a;
   logic [23:0] zp1;
   logic [50:0] s2_pa_in, s2_pa_ff;
   logic [48:0] s2_pw_in, s2_pw_ff;
   logic [23:0] s2_z_ff;
   logic [2:0]  s2_zp1_ff;
   logic        s2_greg_in, s2_greg_ff;

   // stage 3
   logic [7:0]  alpha;
   logic [21:0] wk_q;
   logic [23:0] a_val;
   logic [23:0] s3_b_in, s3_b_ff;
   logic [2:0]  s3_wd_in, s3_wd_ff;
   logic        s3_greg_ff;

   // stage 4
   logic [27:0] cnum;
   logic [56:0] s4_pc_in, s4_pc_ff;
   logic [23:0] s4_b_ff;
   logic [2:0]  s4_wd_ff;
   logic        s4_greg_ff;

   // stage 5
   logic [25:0] d_prod;
   logic [23:0] bd_full;
   logic [14:0] s5_c_in, s5_c_ff;
   logic [8:0]  s5_bd_in, s5_bd_ff;
   logic [2:0]  s5_wd_ff;
   logic        s5_greg_ff;

   // stage 6
   logic [14:0] e_ge;
   logic [3:0]  e_val;
   logic [3:0]  s6_month_in, s6_month_ff;
   logic [4:0]  s6_day_in, s6_day_ff;
   logic [15:0] s6_year_in, s6_year_ff;
   logic [2:0]  s6_wd_ff;
   logic        s6_greg_ff;

   // stage 7
   logic [30:0] s7_py_in, s7_py_ff;
   logic [3:0]  s7_month_ff;
   logic [4:0]  s7_day_ff;
   logic [15:0] s7_year_ff;
   logic [2:0]  s7_wd_ff;
   logic        s7_greg_ff;

   // stage 8
   logic [8:0]  q100;
   logic [6:0]  q100_x;
   logic        is4, is100, is400, leap;
   logic [8:0]  doy_adj;
   date_type    s8_date_in, s8_date_ff;

   always_comb begin
      num_a      = {z, 2'b00} - AlphaBias;
      zp1        = z + 24'd1;
      s2_pa_in   = 51'(num_a[24:0]) * 51'(AlphaMul);
      s2_pw_in   = 49'(zp1) * 49'(WeekMul);
      s2_greg_in = z >= GregStart;
   end

   always_comb begin
      alpha    = s2_pa_ff[AlphaShift +: 8];
      wk_q     = s2_pw_ff[WeekShift +: 22];
      a_val    = s2_greg_ff ? s2_z_ff + 24'd1 + 24'(alpha) - 24'(alpha[7:2]) : s2_z_ff;
      s3_b_in  = a_val + BOffset;
      s3_wd_in = s2_zp1_ff - 3'(wk_q[2:0] * WeekLen);
   end

   always_comb begin
      cnum     = {s3_b_ff, 4'b0000} + 28'({s3_b_ff, 2'b00}) - CBias;
      s4_pc_in = 57'(cnum) * 57'(CentMul);
   end

   always_comb begin
      s5_c_in  = s4_pc_ff[CentShift +: 15];
      d_prod   = 26'(s5_c_in) * DMul;
      bd_full  = s4_b_ff - d_prod[25:2];
      s5_bd_in = bd_full[8:0];
   end

   always_comb begin
      for (int i = 0; i < 15; i++) begin
         e_ge[i] = s5_bd_ff >= EThresh[i];
      end
      e_val       = 4'($countones(e_ge));
      s6_day_in   = 5'(s5_bd_ff - DayBase[e_val]);
      s6_month_in = (e_val < 4'd14) ? e_val - 4'd1 : e_val - 4'd13;
      s6_year_in  = {1'b0, s5_c_ff} - ((s6_month_in > 4'd2) ? YearOffMar : YearOffJan);
   end

   always_comb begin
      s7_py_in = 31'(s6_year_ff[14:0]) * 31'(YearMul);
   end

   always_comb begin
      q100    = s7_py_ff[YearShift +: 9];
      q100_x  = 7'(q100[6:0] * Century);
      is4     = s7_year_ff[1:0] == 2'b00;
      is100   = s7_year_ff[6:0] == q100_x;
      is400   = is100 && (q100[1:0] == 2'b00);
      leap    = s7_greg_ff ? (is400 || (is4 && !is100)) : is4;
      doy_adj = (s7_month_ff > 4'd2) ? (leap ? 9'd1 : 9'd2) : 9'd0;
      s8_date_in.year    = s7_year_ff;
      s8_date_in.month   = s7_month_ff;
      s8_date_in.day     = s7_day_ff;
      s8_date_in.weekday = s7_wd_ff;
      s8_date_in.doy     = MonthBase[s7_month_ff] + 9'(s7_day_ff) - 9'd31 - doy_adj;
      s8_date_in.greg    = s7_greg_ff;
   end

   always_ff @(posedge clock) begin
      s2_pa_ff    <= s2_pa_in;
      s2_pw_ff    <= s2_pw_in;
      s2_z_ff     <= z;
      s2_zp1_ff   <= zp1[2:0];
      s2_greg_ff  <= s2_greg_in;

      s3_b_ff     <= s3_b_in;
      s3_wd_ff    <= s3_wd_in;
      s3_greg_ff  <= s2_greg_ff;

      s4_pc_ff    <= s4_pc_in;
      s4_b_ff     <= s3_b_ff;
      s4_wd_ff    <= s3_wd_ff;
      s4_greg_ff  <= s3_greg_ff;

      s5_c_ff     <= s5_c_in;
      s5_bd_ff    <= s5_bd_in;
      s5_wd_ff    <= s4_wd_ff;
      s5_greg_ff  <= s4_greg_ff;

      s6_month_ff <= s6_month_in;
      s6_day_ff   <= s6_day_in;
      s6_year_ff  <= s6_year_in;
      s6_wd_ff    <= s5_wd_ff;
      s6_greg_ff  <= s5_greg_ff;

      s7_py_ff    <= s7_py_in;
      s7_month_ff <= s6_month_ff;
      s7_day_ff   <= s6_day_ff;
      s7_year_ff  <= s6_year_ff;
      s7_wd_ff    <= s6_wd_ff;
      s7_greg_ff  <= s6_greg_ff;

      s8_date_ff  <= s8_date_in;
   end

   assign date_out = s8_date_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/jdc_time.sv =====
`default_nettype none
module jdc_time (
   input  wire logic                           clock,
   input  wire logic [jdc_pkg::FracWidth-1:0]  f,
   output jdc_pkg::time_type                   time_out
);
   import jdc_pkg::*;

   logic [48:0] s2_ps_in, s2_ps_ff;
   logic [48:0] secs_sum;
   logic [16:0] s3_secs_ff;
   logic [34:0] s4_ph_in, s4_ph_ff;
   logic [16:0] s4_secs_ff;
   logic [16:0] h_secs;
   logic [4:0]  s5_hour_in, s5_hour_ff;
   logic [11:0] s5_rem_in, s5_rem_ff;
   logic [24:0] s6_pm_in, s6_pm_ff;
   logic [4:0]  s6_hour_ff;
   logic [11:0] s6_rem_ff;
   logic [11:0] m_secs;
   time_type    s7_time_in, s7_time_ff, s8_time_ff;

   always_comb begin
      s2_ps_in   = 49'(f) * 49'(SecPerDay);
      secs_sum   = s2_ps_ff + 49'(HalfDay);
      s4_ph_in   = 35'(s3_secs_ff) * 35'(HourMul);
      s5_hour_in = s4_ph_ff[HourShift +: 5];
      h_secs     = 17'(s5_hour_in) * SecPerHour;
      s5_rem_in  = s4_secs_ff[11:0] - h_secs[11:0];
      s6_pm_in   = 25'(s5_rem_ff) * 25'(MinMul);
      s7_time_in.hour   = s6_hour_ff;
      s7_time_in.minute = s6_pm_ff[MinShift +: 6];
      m_secs            = 12'(s7_time_in.minute) * SecPerMin;
      s7_time_in.second = s6_rem_ff[5:0] - m_secs[5:0];
   end

   always_ff @(posedge clock) begin
      s2_ps_ff   <= s2_ps_in;
      s3_secs_ff <= secs_sum[48:32];
      s4_ph_ff   <= s4_ph_in;
      s4_secs_ff <= s3_secs_ff;
      s5_hour_ff <= s5_hour_in;
      s5_rem_ff  <= s5_rem_in;
      s6_pm_ff   <= s6_pm_in;
      s6_hour_ff <= s5_hour_ff;
      s6_rem_ff  <= s5_rem_ff;
      s7_time_ff <= s7_time_in;
      s8_time_ff <= s7_time_ff;
   end

   assign time_out = s8_time_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/julian_day_to_calendar_date.sv =====
`default_nettype none
// channel   ports                        handshake
// request   req_julian_date              start && !busy
// result    rsp_year .. rsp_is_gregorian rsp_valid, one cycle, no backpressure
//
// Eight register stages; a request may enter every cycle and its result
// reaches the result ports when it leaves the last stage. Latency is
// set by the chain of reciprocal multiplies in the date path (alpha,
// century, year/100).
// busy is always low. Reset clears the valid bits only.
// The receiver cannot stall, so the pipeline never holds.
module julian_day_to_calendar_date (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output      logic                         busy,
   input  wire logic [jdc_pkg::JdWidth-1:0]  req_julian_date,
   output      logic                         rsp_valid,
   output      logic signed [15:0]           rsp_year,
   output      logic [3:0]                   rsp_month,
   output      logic [4:0]                   rsp_day_of_month,
   output      logic [4:0]                   rsp_hour,
   output      logic [5:0]                   rsp_minute,
   output      logic [5:0]                   rsp_second,
   output      logic [2:0]                   rsp_weekday,
   output      logic [8:0]                   rsp_day_of_year,
   output      logic                         rsp_is_gregorian
);
   import jdc_pkg::*;

   logic                  accept;
   logic [Stages:1]       vld_in, vld_ff;
   logic [JdWidth:0]      shifted;
   logic [DayWidth-1:0]   s1_z_ff;
   logic [FracWidth-1:0]  s1_f_ff;
   date_type              date;
   time_type              tod;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign vld_in  = {vld_ff[Stages-1:1], accept};
   assign shifted = (JdWidth+1)'(req_julian_date) + (JdWidth+1)'(HalfDay);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_z_ff <= shifted[JdWidth:FracWidth];
      s1_f_ff <= shifted[FracWidth-1:0];
   end

   jdc_date u_date (
      .clock    (clock),
      .z        (s1_z_ff),
      .date_out (date)
   );

   jdc_time u_time (
      .clock    (clock),
      .f        (s1_f_ff),
      .time_out (tod)
   );

   assign rsp_valid        = vld_ff[Stages];
   assign rsp_year         = date.year;
   assign rsp_month        = date.month;
   assign rsp_day_of_month = date.day;
   assign rsp_hour         = tod.hour;
   assign rsp_minute       = tod.minute;
   assign rsp_second       = tod.second;
   assign rsp_weekday      = date.weekday;
   assign rsp_day_of_year  = date.doy;
   assign rsp_is_gregorian = date.greg;

endmodule
`default_nettype wire

// ===== verif/tb_julian_day_to_calendar_date.sv =====
`default_nettype none
module tb_julian_day_to_calendar_date;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int JdW = jdc_pkg::JdWidth;
   localparam longint unsigned HalfDayQ32 = 64'h8000_0000;
   localparam longint unsigned FracMask = 64'hFFFF_FFFF;
   localparam longint GregFirstDay = longint'(jdc_pkg::GregStart);
   localparam int NumRandom = 500;
   localparam int QuietTail = 80;
   localparam int SettleCycles = 16;
   localparam int StallLimit = 1000;

   typedef struct {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day_of_month;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [2:0]         weekday;
      logic [8:0]         day_of_year;
      logic               is_gregorian;
   } cal_date_type;

   class calendar_book;
      cal_date_type due_dates[$];
      int errors = 0;
      int requests = 0;
      int results = 0;
      int gregorian_seen = 0;
      int hour24_seen = 0;
      int bc_seen = 0;

      function cal_date_type convert_jd(logic [JdW-1:0] jd);
         cal_date_type r;
         longint unsigned sum, frac, secs;
         longint z, alpha, a, b, c, d, e, dom, mon, yr, k, doy, wd;
         bit greg;
         sum = 64'(jd) + HalfDayQ32;
         z = longint'(sum >> 32);
         frac = sum & FracMask;
         greg = z >= GregFirstDay;
         if (greg) begin
            alpha = (4 * z - 7468865) / 146097;
            a = z + 1 + alpha - alpha / 4;
         end else begin
            a = z;
         end
         b = a + 1524;
         c = (20 * b - 2442) / 7305;
         d = (1461 * c) / 4;
         e = (10000 * (b - d)) / 306001;
         dom = b - d - (306001 * e) / 10000;
         mon = (e < 14) ? e - 1 : e - 13;
         yr = (mon > 2) ? c - 4716 : c - 4715;
         secs = (frac * 64'd86400 + HalfDayQ32) >> 32;
         if (greg) begin
            if (yr % 400 == 0) k = 1;
            else if (yr % 100 == 0) k = 2;
            else if (yr % 4 == 0) k = 1;
            else k = 2;
         end else begin
            k = (yr % 4 == 0) ? 1 : 2;
         end
         doy = (275 * mon) / 9 - k * ((mon + 9) / 12) + dom - 30 - 1;
         wd = (z + 1) % 7;
         r.year = yr[15:0];
         r.month = mon[3:0];
         r.day_of_month = dom[4:0];
         r.hour = 5'(secs / 3600);
         r.minute = 6'((secs % 3600) / 60);
         r.second = 6'(secs % 60);
         r.weekday = wd[2:0];
         r.day_of_year = doy[8:0];
         r.is_gregorian = greg;
         return r;
      endfunction

      function void note_request(logic [JdW-1:0] jd);
         cal_date_type p;
         p = convert_jd(jd);
         requests++;
         if (p.is_gregorian) gregorian_seen++;
         if (p.hour == 5'd24) hour24_seen++;
         if (p.year < 0) bc_seen++;
         due_dates.push_back(p);
      endfunction

      function void compare_field(string name, longint exp_v, longint got_v);
         if (exp_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
         end
      endfunction

      function void check_result(cal_date_type got);
         cal_date_type exp_d;
         results++;
         if (due_dates.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual year %0d month %0d day %0d",
                     $time, got.year, got.month, got.day_of_month);
            return;
         end
         exp_d = due_dates.pop_front();
         compare_field("year", longint'(exp_d.year), longint'(got.year));
         compare_field("month", exp_d.month, got.month);
         compare_field("day_of_month", exp_d.day_of_month, got.day_of_month);
         compare_field("hour", exp_d.hour, got.hour);
         compare_field("minute", exp_d.minute, got.minute);
         compare_field("second", exp_d.second, got.second);
         compare_field("weekday", exp_d.weekday, got.weekday);
         compare_field("day_of_year", exp_d.day_of_year, got.day_of_year);
         compare_field("is_gregorian", exp_d.is_gregorian, got.is_gregorian);
      endfunction

      function int pending();
         return due_dates.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [JdW-1:0] req_julian_date = '0;
   logic busy;
   logic rsp_valid;
   logic signed [15:0] rsp_year;
   logic [3:0] rsp_month;
   logic [4:0] rsp_day_of_month;
   logic [4:0] rsp_hour;
   logic [5:0] rsp_minute;
   logic [5:0] rsp_second;
   logic [2:0] rsp_weekday;
   logic [8:0] rsp_day_of_year;
   logic rsp_is_gregorian;

   calendar_book book = new();
   int stall_cycles = 0;

   julian_day_to_calendar_date dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_julian_date  (req_julian_date),
      .rsp_valid        (rsp_valid),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_weekday      (rsp_weekday),
      .rsp_day_of_year  (rsp_day_of_year),
      .rsp_is_gregorian (rsp_is_gregorian)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cal_date_type got;
      if (!reset) begin
         if (start && !busy) book.note_request(req_julian_date);
         if (rsp_valid) begin
            got.year = rsp_year;
            got.month = rsp_month;
            got.day_of_month = rsp_day_of_month;
            got.hour = rsp_hour;
            got.minute = rsp_minute;
            got.second = rsp_second;
            got.weekday = rsp_weekday;
            got.day_of_year = rsp_day_of_year;
            got.is_gregorian = rsp_is_gregorian;
            book.check_result(got);
         end
         if ((start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("%0t: timeout, %0d requests still outstanding", $time, book.pending());
            $display("tb_julian_day_to_calendar_date: done, errors");
            $finish;
         end
      end
   end

   // day number (noon based) of a calendar date, Gregorian or Julian rules
   function automatic longint day_number(longint y, longint m, longint d, bit greg);
      longint a, yy, mm, n;
      a = (14 - m) / 12;
      yy = y + 4800 - a;
      mm = m + 12 * a - 3;
      n = d + (153 * mm + 2) / 5 + 365 * yy + yy / 4;
      if (greg) return n - yy / 100 + yy / 400 - 32045;
      return n - 32083;
   endfunction

   function automatic logic [JdW-1:0] make_jd(longint z, longint unsigned f);
      longint unsigned v;
      v = z;
      v = (v << 32) + f - HalfDayQ32;
      return v[JdW-1:0];
   endfunction

   function automatic longint unsigned pick_frac();
      case ($urandom_range(0, 4))
         0: return 64'(32'hFFFF_FFFF - $urandom_range(0, 30000));
         1: return 64'($urandom_range(0, 30000));
         2: return 64'(((2 * $urandom_range(0, 127) + 1) << 24) + $urandom_range(0, 2) - 1);
         default: return 64'($urandom);
      endcase
   endfunction

   function automatic logic [JdW-1:0] pick_jd();
      logic [63:0] raw;
      longint y;
      case ($urandom_range(0, 9))
         0, 1: begin
            raw = {$urandom, $urandom};
            return raw[JdW-1:0];
         end
         2: return make_jd(GregFirstDay + $urandom_range(0, 6) - 3, pick_frac());
         3: begin
            y = 100 * longint'($urandom_range(16, 182));
            return make_jd(day_number(y, 3, 1, 1'b1) + $urandom_range(0, 4) - 2, pick_frac());
         end
         4: begin
            y = 100 * longint'($urandom_range(0, 62)) - 4700;
            return make_jd(day_number(y, 3, 1, 1'b0) + $urandom_range(0, 4) - 2, pick_frac());
         end
         5: return make_jd(longint'($urandom_range(1, 8388607)), pick_frac());
         default: return make_jd(longint'($urandom_range(1, 8388607)), 64'($urandom));
      endcase
   endfunction

   task automatic send_request(input logic [JdW-1:0] jd);
      @(negedge clock);
      start <= 1'b1;
      req_julian_date <= jd;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      hold_off(1);
      while (book.pending() != 0) @(posedge clock);
   endtask

   initial begin
      longint z2000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      z2000 = day_number(2000, 2, 29, 1'b1);
      send_request('0);
      send_request({JdW{1'b1}});
      send_request(make_jd(longint'(1) << 23, 0));
      send_request(make_jd(0, 64'hFFFF_FFFF));
      send_request(make_jd(GregFirstDay - 1, 0));
      send_request(make_jd(GregFirstDay, 0));
      send_request(make_jd(z2000, 64'hFFFF_FFFF));
      send_request(make_jd(z2000 + 1, 64'h0100_0000));
      send_request(make_jd(z2000 + 1, 64'h00FF_FFFF));
      send_request(make_jd(day_number(1900, 2, 28, 1'b1), 64'h4000_0000));
      send_request(make_jd(day_number(1900, 3, 1, 1'b1), 64'hC000_0000));
      send_request(make_jd(day_number(1500, 2, 29, 1'b0), 64'h1234_5678));
      send_request(make_jd(day_number(-4712, 2, 29, 1'b0), 64'h8000_0000));
      send_request(make_jd(day_number(-4712, 12, 31, 1'b0), 64'hFFFF_0000));
      send_request(make_jd(day_number(2000, 12, 31, 1'b1), 64'h0000_0001));
      send_request(make_jd(day_number(1999, 12, 31, 1'b1), 64'hFFFF_9E00));
      send_request(make_jd(day_number(2001, 1, 1, 1'b1), 64'h0));
      send_request(make_jd(day_number(18254, 1, 1, 1'b1), 64'h7FFF_FFFF));
      send_request(make_jd(8388607, 64'hFFFF_FFFF));
      send_request({1'b0, {(JdW - 1){1'b1}}});
      send_request({1'b1, {(JdW - 1){1'b0}}});
      wait_drained();

      for (int i = 0; i < NumRandom; i++) begin
         if (i == NumRandom / 2) wait_drained();
         if (i < NumRandom - QuietTail && $urandom_range(0, 7) == 0)
            hold_off($urandom_range(1, 15));
         send_request(pick_jd());
      end
      hold_off(1);
      while (book.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("run covered %0d requests and %0d results: %0d Gregorian, %0d Julian, %0d BCE",
               book.requests, book.results, book.gregorian_seen,
               book.requests - book.gregorian_seen, book.bc_seen);
      $display("%0d dates rounded up to hour 24, %0d mismatches", book.hour24_seen, book.errors);
      if (book.errors == 0) begin
         $display("tb_julian_day_to_calendar_date: done, clean");
      end else begin
         $display("tb_julian_day_to_calendar_date: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
